>>> rtl/ppp_pkg.sv
// ----------------------------------------------------------------------------
// ppp_pkg
// Shared types, constants and the divider step for the point projection pipe.
// ----------------------------------------------------------------------------
package ppp_pkg;

  // Register indexes of the configuration port
  localparam logic [3:0] RegRotRow0   = 4'd0;
  localparam logic [3:0] RegRotRow1   = 4'd1;
  localparam logic [3:0] RegRotRow2   = 4'd2;
  localparam logic [3:0] RegOriginX   = 4'd3;
  localparam logic [3:0] RegOriginY   = 4'd4;
  localparam logic [3:0] RegOriginZ   = 4'd5;
  localparam logic [3:0] RegScreenDst = 4'd6;
  localparam logic [3:0] RegPointSize = 4'd7;

  // Reset values
  localparam logic [47:0] RotRow0Rst   = 48'h0000_0000_4000;
  localparam logic [47:0] RotRow1Rst   = 48'h0000_4000_0000;
  localparam logic [47:0] RotRow2Rst   = 48'h4000_0000_0000;
  localparam logic [30:0] ScreenDstRst = 31'd32768000;
  localparam logic [30:0] PointSizeRst = 31'd65536;

  // Pipeline shape: subtract, multiply, sum, scale multiply, numerator,
  // one stage per quotient bit, output
  localparam int QBits     = 32;
  localparam int DivFirst  = 6;
  localparam int NumStages = DivFirst + QBits;

  // Rotated point, Q.30
  typedef struct packed {
    logic signed [50:0] cx;
    logic signed [50:0] cy;
    logic signed [50:0] cz;
  } xf_t;

  // One divider lane: partial remainder, numerator low bits that become
  // the quotient, overflow flag
  typedef struct packed {
    logic [48:0] rem;
    logic [31:0] lq;
    logic        ovf;
  } lane_t;

  typedef struct packed {
    logic [48:0] den;
    logic        vis;
    logic        neg_x;
    logic        neg_y;
    lane_t       lx;
    lane_t       ly;
    lane_t       ld;
  } div_t;

  // One restoring division step
  function automatic lane_t div_step(lane_t l, logic [48:0] den);
    logic [49:0] rem2;
    logic [49:0] diff;
    logic        ge;
    lane_t       r;
    rem2   = {l.rem, l.lq[31]};
    diff   = rem2 - {1'b0, den};
    ge     = (rem2 >= {1'b0, den});
    r.rem  = ge ? diff[48:0] : rem2[48:0];
    r.lq   = {l.lq[30:0], ge};
    r.ovf  = l.ovf;
    return r;
  endfunction

endpackage

>>> rtl/ppp_xform.sv
// ----------------------------------------------------------------------------
// ppp_xform
// Origin subtract, matrix products and row sums (three register stages).
// ----------------------------------------------------------------------------
module ppp_xform (
  input  logic               clk_i,
  input  logic [2:0]         en_i,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic signed [31:0] point_z_i,
  input  logic signed [31:0] origin_x_i,
  input  logic signed [31:0] origin_y_i,
  input  logic signed [31:0] origin_z_i,
  input  logic [47:0]        rot_row0_i,
  input  logic [47:0]        rot_row1_i,
  input  logic [47:0]        rot_row2_i,
  output ppp_pkg::xf_t       xf_o
);

  logic signed [32:0] r_q [3];
  logic signed [48:0] p_q [3][3];
  logic signed [48:0] p_d [3][3];
  logic [47:0]        rows [3];
  ppp_pkg::xf_t       xf_q;
  ppp_pkg::xf_t       xf_d;

  assign rows[0] = rot_row0_i;
  assign rows[1] = rot_row1_i;
  assign rows[2] = rot_row2_i;

  // Stage 1: camera-relative point
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      r_q[0] <= $signed({point_x_i[31], point_x_i}) - $signed({origin_x_i[31], origin_x_i});
      r_q[1] <= $signed({point_y_i[31], point_y_i}) - $signed({origin_y_i[31], origin_y_i});
      r_q[2] <= $signed({point_z_i[31], point_z_i}) - $signed({origin_z_i[31], origin_z_i});
    end
  end

  // Stage 2: nine products, row i times component j
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        p_d[i][j] = r_q[j] * $signed(rows[i][16*j +: 16]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      p_q <= p_d;
    end
  end

  // Stage 3: row sums
  always_comb begin
    xf_d.cx = 51'(p_q[0][0]) + 51'(p_q[0][1]) + 51'(p_q[0][2]);
    xf_d.cy = 51'(p_q[1][0]) + 51'(p_q[1][1]) + 51'(p_q[1][2]);
    xf_d.cz = 51'(p_q[2][0]) + 51'(p_q[2][1]) + 51'(p_q[2][2]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      xf_q <= xf_d;
    end
  end

  assign xf_o = xf_q;

endmodule

>>> rtl/ppp_scale.sv
// ----------------------------------------------------------------------------
// ppp_scale
// Numerators times screen distance, split products, divider set-up.
// ----------------------------------------------------------------------------
module ppp_scale (
  input  logic          clk_i,
  input  logic [1:0]    en_i,
  input  ppp_pkg::xf_t  xf_i,
  input  logic [30:0]   screen_distance_i,
  input  logic [30:0]   point_size_i,
  output ppp_pkg::div_t div_o
);

  logic [49:0]   mag_x;
  logic [49:0]   mag_y;
  logic [55:0]   plo_x_q, phi_x_q, plo_y_q, phi_y_q;
  logic [61:0]   psd_q;
  logic [48:0]   den_q;
  logic          vis_q, neg_x_q, neg_y_q;
  logic [80:0]   num_x, num_y;
  logic [75:0]   num_d;
  ppp_pkg::div_t div_d;
  ppp_pkg::div_t div_q;

  // Stage 4: magnitudes and partial products
  assign mag_x = xf_i.cx[50] ? 50'(-xf_i.cx) : xf_i.cx[49:0];
  assign mag_y = xf_i.cy[50] ? 50'(-xf_i.cy) : xf_i.cy[49:0];

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      plo_x_q <= 56'(mag_x[24:0] * screen_distance_i);
      phi_x_q <= 56'(mag_x[49:25] * screen_distance_i);
      plo_y_q <= 56'(mag_y[24:0] * screen_distance_i);
      phi_y_q <= 56'(mag_y[49:25] * screen_distance_i);
      psd_q   <= point_size_i * screen_distance_i;
      den_q   <= xf_i.cz[48:0];
      vis_q   <= (xf_i.cz > 51'sd0);
      neg_x_q <= xf_i.cx[50];
      neg_y_q <= xf_i.cy[50];
    end
  end

  // Stage 5: full numerators, overflow check on the upper part
  always_comb begin
    num_x = {phi_x_q, 25'd0} + 81'(plo_x_q);
    num_y = {phi_y_q, 25'd0} + 81'(plo_y_q);
    num_d = {psd_q, 14'd0};
    div_d.den    = den_q;
    div_d.vis    = vis_q;
    div_d.neg_x  = neg_x_q;
    div_d.neg_y  = neg_y_q;
    div_d.lx.rem = num_x[80:32];
    div_d.lx.lq  = num_x[31:0];
    div_d.lx.ovf = (num_x[80:32] >= den_q);
    div_d.ly.rem = num_y[80:32];
    div_d.ly.lq  = num_y[31:0];
    div_d.ly.ovf = (num_y[80:32] >= den_q);
    div_d.ld.rem = {5'd0, num_d[75:32]};
    div_d.ld.lq  = num_d[31:0];
    div_d.ld.ovf = ({5'd0, num_d[75:32]} >= den_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      div_q <= div_d;
    end
  end

  assign div_o = div_q;

endmodule

>>> rtl/ppp_div_step.sv
// ----------------------------------------------------------------------------
// ppp_div_step
// One quotient bit for all three divider lanes, registered.
// ----------------------------------------------------------------------------
module ppp_div_step (
  input  logic          clk_i,
  input  logic          en_i,
  input  ppp_pkg::div_t div_i,
  output ppp_pkg::div_t div_o
);

  ppp_pkg::div_t div_d;
  ppp_pkg::div_t div_q;

  always_comb begin
    div_d    = div_i;
    div_d.lx = ppp_pkg::div_step(div_i.lx, div_i.den);
    div_d.ly = ppp_pkg::div_step(div_i.ly, div_i.den);
    div_d.ld = ppp_pkg::div_step(div_i.ld, div_i.den);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_d;
    end
  end

  assign div_o = div_q;

endmodule

>>> rtl/point_perspective_projection.sv
// ----------------------------------------------------------------------------
// point_perspective_projection
// Camera transform, perspective divide: one Q16.16 point per unstalled cycle.
// ----------------------------------------------------------------------------
// Throughput: one point per cycle unless the output stalls; one quotient bit
// per stage in the divider.
// Empty stages are filled while the output is stalled.
// Reset: pipeline valid bits clear, registers return to identity matrix,
// zero origin, distance 500.0 and dot size 1.0.
module point_perspective_projection (
  input  logic               clk_i,
  input  logic               rst_ni,
  // point requests
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic signed [31:0] point_z_i,
  // results
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               visible_o,
  output logic signed [31:0] screen_x_o,
  output logic signed [31:0] screen_y_o,
  output logic [30:0]        dot_size_o,
  // configuration writes
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [3:0]         cfg_index_i,
  input  logic [47:0]        cfg_data_i
);

  localparam int N = ppp_pkg::NumStages;

  logic [47:0]        rot_row0_q, rot_row1_q, rot_row2_q;
  logic signed [31:0] origin_x_q, origin_y_q, origin_z_q;
  logic [30:0]        screen_dst_q, point_size_q;

  logic [N:1]     v_q;
  logic [N+1:1]   rdy;
  ppp_pkg::xf_t   xf;
  ppp_pkg::div_t  dv [ppp_pkg::QBits+1];

  logic [31:0]    sx_d, sy_d;
  logic [30:0]    ds_d;
  logic           vis_q;
  logic [31:0]    sx_q, sy_q;
  logic [30:0]    ds_q;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_row0_q   <= ppp_pkg::RotRow0Rst;
      rot_row1_q   <= ppp_pkg::RotRow1Rst;
      rot_row2_q   <= ppp_pkg::RotRow2Rst;
      origin_x_q   <= '0;
      origin_y_q   <= '0;
      origin_z_q   <= '0;
      screen_dst_q <= ppp_pkg::ScreenDstRst;
      point_size_q <= ppp_pkg::PointSizeRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ppp_pkg::RegRotRow0:   rot_row0_q   <= cfg_data_i;
        ppp_pkg::RegRotRow1:   rot_row1_q   <= cfg_data_i;
        ppp_pkg::RegRotRow2:   rot_row2_q   <= cfg_data_i;
        ppp_pkg::RegOriginX:   origin_x_q   <= cfg_data_i[31:0];
        ppp_pkg::RegOriginY:   origin_y_q   <= cfg_data_i[31:0];
        ppp_pkg::RegOriginZ:   origin_z_q   <= cfg_data_i[31:0];
        ppp_pkg::RegScreenDst: screen_dst_q <= cfg_data_i[30:0];
        ppp_pkg::RegPointSize: point_size_q <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // Per-stage ready: a stage loads when empty or when its successor loads
  assign rdy[N+1] = ~out_stall_i;
  for (genvar k = 1; k <= N; k++) begin : g_rdy
    assign rdy[k] = ~v_q[k] | rdy[k+1];
  end

  assign in_stall_o = ~rdy[1];

  // Valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[1]) begin
        v_q[1] <= in_valid_i;
      end
      for (int k = 2; k <= N; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign out_valid_o = v_q[N];

  // Stages 1 to 3
  ppp_xform u_xform (
    .clk_i      (clk_i),
    .en_i       (rdy[3:1]),
    .point_x_i  (point_x_i),
    .point_y_i  (point_y_i),
    .point_z_i  (point_z_i),
    .origin_x_i (origin_x_q),
    .origin_y_i (origin_y_q),
    .origin_z_i (origin_z_q),
    .rot_row0_i (rot_row0_q),
    .rot_row1_i (rot_row1_q),
    .rot_row2_i (rot_row2_q),
    .xf_o       (xf)
  );

  // Stages 4 and 5
  ppp_scale u_scale (
    .clk_i             (clk_i),
    .en_i              (rdy[5:4]),
    .xf_i              (xf),
    .screen_distance_i (screen_dst_q),
    .point_size_i      (point_size_q),
    .div_o             (dv[0])
  );

  // Divider, one quotient bit per stage
  for (genvar i = 0; i < ppp_pkg::QBits; i++) begin : g_div
    ppp_div_step u_step (
      .clk_i (clk_i),
      .en_i  (rdy[ppp_pkg::DivFirst+i]),
      .div_i (dv[i]),
      .div_o (dv[i+1])
    );
  end

  // Output stage: saturate, restore sign, zero when depth is not positive
  always_comb begin
    logic [31:0] qx, qy;
    logic [31:0] lim_x, lim_y;
    ppp_pkg::div_t f;
    f     = dv[ppp_pkg::QBits];
    lim_x = f.neg_x ? 32'h8000_0000 : 32'h7FFF_FFFF;
    lim_y = f.neg_y ? 32'h8000_0000 : 32'h7FFF_FFFF;
    qx    = (f.lx.ovf || f.lx.lq > lim_x) ? lim_x : f.lx.lq;
    qy    = (f.ly.ovf || f.ly.lq > lim_y) ? lim_y : f.ly.lq;
    sx_d  = f.vis ? (f.neg_x ? 32'(-qx) : qx) : 32'd0;
    sy_d  = f.vis ? (f.neg_y ? 32'(-qy) : qy) : 32'd0;
    if (!f.vis) begin
      ds_d = '0;
    end else if (f.ld.ovf || f.ld.lq[31]) begin
      ds_d = 31'h7FFF_FFFF;
    end else begin
      ds_d = f.ld.lq[30:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[N]) begin
      vis_q <= dv[ppp_pkg::QBits].vis;
      sx_q  <= sx_d;
      sy_q  <= sy_d;
      ds_q  <= ds_d;
    end
  end

  assign visible_o  = vis_q;
  assign screen_x_o = sx_q;
  assign screen_y_o = sy_q;
  assign dot_size_o = ds_q;

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the point projection pipe: directed points under
// the reset camera, then extreme and random camera settings with random point
// streams, bursty requests and output stalls, every result scored in order
// against listed values or a bit-exact projection predictor.
// ----------------------------------------------------------------------------
module tb;

  typedef struct packed {
    logic               vis;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic [30:0]        ds;
  } proj_t;

  typedef struct {
    logic [31:0] px, py, pz;
    logic        typed;
    proj_t       res;
  } pt_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic signed [31:0] point_x_i = '0, point_y_i = '0, point_z_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               visible_o;
  logic signed [31:0] screen_x_o, screen_y_o;
  logic [30:0]        dot_size_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [3:0]         cfg_index_i = '0;
  logic [47:0]        cfg_data_i = '0;

  // camera copy held by the predictor
  logic [47:0] cam_row [3];
  logic [31:0] cam_org [3];
  logic [30:0] cam_dist, cam_size;

  proj_t expected_q [$];
  int    errors = 0;

  point_perspective_projection u_top (.*);

  always #1 clk_i = ~clk_i;

  // signed num * d / den, truncated toward zero, clamped to 32 bits
  function automatic logic [31:0] project(logic signed [63:0] num, logic [30:0] d,
                                          logic [63:0] den);
    logic [127:0] mag, q;
    logic         neg;
    neg = num < 0;
    mag = neg ? 128'(-num) : 128'(num);
    q   = (mag * d) / den;
    if (neg) begin
      if (q > 128'h8000_0000) q = 128'h8000_0000;
      return 32'(-q);
    end
    if (q > 128'h7fff_ffff) q = 128'h7fff_ffff;
    return q[31:0];
  endfunction

  function automatic proj_t predict_projection(logic [31:0] px, logic [31:0] py,
                                               logic [31:0] pz);
    logic signed [63:0] rel [3];
    logic signed [63:0] cam [3];
    logic signed [63:0] e;
    logic [127:0]       v;
    proj_t              r;
    rel[0] = $signed(px) - $signed(cam_org[0]);
    rel[1] = $signed(py) - $signed(cam_org[1]);
    rel[2] = $signed(pz) - $signed(cam_org[2]);
    for (int i = 0; i < 3; i++) begin
      cam[i] = 0;
      for (int k = 0; k < 3; k++) begin
        e = $signed(cam_row[i][16*k +: 16]);
        cam[i] = cam[i] + rel[k] * e;
      end
    end
    r = '0;
    // depth zero or behind the eye: all fields zero
    if (cam[2] <= 0) return r;
    r.vis = 1'b1;
    r.sx  = project(cam[0], cam_dist, 64'(cam[2]));
    r.sy  = project(cam[1], cam_dist, 64'(cam[2]));
    v = ((128'(cam_size) * cam_dist) << 14) / 64'(cam[2]);
    r.ds  = (v > 128'h7fff_ffff) ? 31'h7fff_ffff : v[30:0];
    return r;
  endfunction

  // one config request; valid stays up for a following write
  task automatic cfg_write(logic [3:0] idx, logic [47:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      ppp_pkg::RegRotRow0, ppp_pkg::RegRotRow1, ppp_pkg::RegRotRow2:
        cam_row[idx] = data;
      ppp_pkg::RegOriginX, ppp_pkg::RegOriginY, ppp_pkg::RegOriginZ:
        cam_org[idx - ppp_pkg::RegOriginX] = data[31:0];
      ppp_pkg::RegScreenDst: cam_dist = data[30:0];
      ppp_pkg::RegPointSize: cam_size = data[30:0];
      default: ;
    endcase
  endtask

  task automatic load_camera(logic [47:0] r0, logic [47:0] r1, logic [47:0] r2,
                             logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                             logic [30:0] d, logic [30:0] s);
    cfg_write(ppp_pkg::RegRotRow0, r0);
    cfg_write(ppp_pkg::RegRotRow1, r1);
    cfg_write(ppp_pkg::RegRotRow2, r2);
    cfg_write(ppp_pkg::RegOriginX, {16'(0), ox});
    cfg_write(ppp_pkg::RegOriginY, {16'(0), oy});
    cfg_write(ppp_pkg::RegOriginZ, {16'(0), oz});
    cfg_write(ppp_pkg::RegScreenDst, {17'(0), d});
    cfg_write(ppp_pkg::RegPointSize, {17'(0), s});
    cfg_valid_i <= 1'b0;
  endtask

  // offer one point and hold it until the request is taken
  task automatic send_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                            logic typed, proj_t res);
    in_valid_i <= 1'b1;
    point_x_i  <= px;
    point_y_i  <= py;
    point_z_i  <= pz;
    do @(posedge clk_i); while (in_stall_o);
    expected_q.push_back(typed ? res : predict_projection(px, py, pz));
  endtask

  // idle until the pipe is empty
  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (45) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 2**21)) - 2**20);
      2: return 32'($signed($urandom_range(0, 2**25)) - 2**24);
      default: return $urandom_range(0, 1) ? 32'h7fff_ffff - $urandom_range(0, 3)
                                          : 32'h8000_0000 + $urandom_range(0, 3);
    endcase
  endfunction

  function automatic logic [47:0] rand_row();
    logic [47:0] r;
    for (int k = 0; k < 3; k++)
      r[16*k +: 16] = $urandom_range(0, 1) ? 16'($urandom())
                                           : 16'($signed($urandom_range(0, 32768)) - 16384);
    return r;
  endfunction

  // receiver: free run, one long hold so the pipe backs up, then random stalls
  initial begin
    int run, pct;
    repeat (150) @(posedge clk_i);
    repeat (300) begin
      out_stall_i <= 1'b1;
      @(posedge clk_i);
    end
    forever begin
      run = $urandom_range(5, 80);
      pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 90);
      repeat (run) begin
        out_stall_i <= ($urandom_range(1, 100) <= pct);
        @(posedge clk_i);
      end
    end
  end

  // result scoreboard
  always @(posedge clk_i) begin
    proj_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result vis=%0b x=%h y=%h size=%h", $time,
                 visible_o, screen_x_o, screen_y_o, dot_size_o);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (visible_o !== exp_r.vis) begin
          $display("%0t: visible expected %0b actual %0b", $time, exp_r.vis, visible_o);
          errors++;
        end
        if (screen_x_o !== exp_r.sx) begin
          $display("%0t: screen_x expected %h actual %h", $time, exp_r.sx, screen_x_o);
          errors++;
        end
        if (screen_y_o !== exp_r.sy) begin
          $display("%0t: screen_y expected %h actual %h", $time, exp_r.sy, screen_y_o);
          errors++;
        end
        if (dot_size_o !== exp_r.ds) begin
          $display("%0t: dot_size expected %h actual %h", $time, exp_r.ds, dot_size_o);
          errors++;
        end
      end
    end
  end

  // stimulus
  initial begin
    pt_row_t dir_tbl [$];
    int      gap, burst;
    proj_t   nul;
    nul = '0;
    cam_row[0] = ppp_pkg::RotRow0Rst;
    cam_row[1] = ppp_pkg::RotRow1Rst;
    cam_row[2] = ppp_pkg::RotRow2Rst;
    cam_org    = '{default: '0};
    cam_dist   = ppp_pkg::ScreenDstRst;
    cam_size   = ppp_pkg::PointSizeRst;

    // reset camera: identity, origin zero, distance 500.0, size 1.0
    dir_tbl = '{
      '{32'h0, 32'h0, 32'h0001_0000, 1'b1, '{1'b1, 32'h0, 32'h0, 31'd32768000}},
      '{32'h0, 32'h0, 32'h0, 1'b1, '0},
      '{32'h0, 32'h0, 32'hffff_0000, 1'b1, '0},
      '{32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b1,
        '{1'b1, 32'd32768000, 32'd32768000, 31'd32768000}},
      '{32'hffff_0000, 32'hffff_0000, 32'h0001_0000, 1'b1,
        '{1'b1, -32'sd32768000, -32'sd32768000, 31'd32768000}},
      '{32'h7fff_ffff, 32'h7fff_ffff, 32'h1, 1'b1,
        '{1'b1, 32'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_ffff}},
      '{32'h8000_0000, 32'h8000_0000, 32'h1, 1'b1,
        '{1'b1, 32'h8000_0000, 32'h8000_0000, 31'h7fff_ffff}},
      '{32'h0, 32'h0, 32'h8000_0000, 1'b1, '0},
      '{32'h0, 32'h0, 32'h7fff_ffff, 1'b0, '0},
      '{32'h1, 32'hffff_ffff, 32'h0000_8000, 1'b0, '0},
      '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b0, '0},
      '{32'h0123_4567, 32'hfedc_ba98, 32'h0002_0000, 1'b0, '0}
    };

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (dir_tbl[i])
      send_point(dir_tbl[i].px, dir_tbl[i].py, dir_tbl[i].pz,
                 dir_tbl[i].typed, dir_tbl[i].res);
    drain();

    // out-of-range indexes are ignored by the block
    cfg_write(4'd8, '1);
    cfg_write(4'd15, 48'h1234_5678_9abc);
    cfg_valid_i <= 1'b0;
    send_point(32'h0001_0000, 32'h0, 32'h0001_0000, 1'b0, nul);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: load_camera(48'h7fff_7fff_7fff, 48'h7fff_7fff_7fff, 48'h7fff_7fff_7fff,
                       32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                       31'h7fff_ffff, 31'h7fff_ffff);
        1: load_camera(48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000,
                       32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h0, 31'h0);
        2: load_camera(ppp_pkg::RotRow0Rst, ppp_pkg::RotRow1Rst, ppp_pkg::RotRow2Rst,
                       32'h0, 32'h0, 32'h0, 31'h0001_0000, 31'h7fff_ffff);
        default: load_camera(rand_row(), rand_row(), rand_row(),
                             rand_coord(), rand_coord(), rand_coord(),
                             31'($urandom_range(0, 3) == 0 ? $urandom()
                                                           : $urandom_range(0, 2**26)),
                             31'($urandom_range(0, 3) == 0 ? $urandom()
                                                           : $urandom_range(0, 2**20)));
      endcase
      // bursts of points with random gaps
      for (int n = 0; n < 168; ) begin
        burst = $urandom_range(1, 24);
        for (int b = 0; b < burst && n < 168; b++, n++) begin
          send_point(rand_coord(), rand_coord(), rand_coord(), 1'b0, nul);
          if (n == 84 && ph == 3) drain();
        end
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        if (gap != 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      drain();
    end

    if (errors == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

  // watchdog
  initial begin
    #1_000_000;
    $display("tb failed");
    $finish;
  end

endmodule
